// ===== sv/its_pkg.sv =====
// Shared types, widths and codes for the interval timer slot table.
package its_pkg;

    localparam int TIME_W        = 32;
    localparam int PERIOD_W      = 31;
    localparam int KIND_W        = 2;
    localparam int SLOT_W        = 3;
    localparam int WRAP_W        = 16;
    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int RES_IDX_W     = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam logic [WRAP_W-1:0] WRAP_MAX = {WRAP_W{1'b1}};

    typedef logic [KIND_W-1:0] kind_t;

    localparam logic  CMD_TICK       = 1'b0;
    localparam logic  CMD_ADD        = 1'b1;

    localparam kind_t KIND_FIRED     = 2'd0;
    localparam kind_t KIND_IDLE_TICK = 2'd1;
    localparam kind_t KIND_ADDED     = 2'd2;
    localparam kind_t KIND_REFUSED   = 2'd3;

endpackage

// ===== sv/interval_timer_slots.sv =====
// Interval timer slot table: slot memory, scan sequencer and result output register.
// An add request writes a free slot, if any, in its accepting cycle and offers its single result from the emit state.
// A tick request scans every slot through one read port of the slot memory, one slot a cycle,
// then delivers one result per cycle while the output is not stalled.
// Reset clears the active flags, the wrap counter and all control; the memory is not cleared.
module interval_timer_slots
    import its_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [TIME_W-1:0]   now_ms,
    input  logic [PERIOD_W-1:0] interval_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KIND_W-1:0]   kind,
    output logic [SLOT_W-1:0]   slot,
    output logic [WRAP_W-1:0]   wrap_total,
    output logic                last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int MEM_W = PERIOD_W + TIME_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;
    logic [WRAP_W-1:0]     wrap_reg, wrap_next;
    logic                  wrapped_reg, wrapped_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic [RES_CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic [RES_CNT_W-1:0]  emit_reg, emit_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    kind_t                 single_kind_reg, single_kind_next;
    logic [SLOT_W-1:0]     single_slot_reg, single_slot_next;
    logic [SLOT_W-1:0]     queue_reg [MAX_RESULTS];

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [WRAP_W-1:0]     out_wrap_reg, out_wrap_next;
    logic                  out_last_reg, out_last_next;

    logic [MEM_W-1:0]      mem [SLOT_COUNT];
    logic [MEM_W-1:0]      rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;

    logic                  in_accept;
    logic                  out_free;
    logic                  any_free;
    logic [IDX_W-1:0]      free_idx;
    logic [PERIOD_W-1:0]   rd_period;
    logic [TIME_W-1:0]     rd_ref;
    logic [TIME_W-1:0]     elapsed;
    logic                  went_back;
    logic                  fires;
    logic                  chk_active;
    logic                  q_we;
    logic [RES_IDX_W-1:0]  q_waddr;
    logic [RES_CNT_W-1:0]  res_total;
    logic                  emit_last;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign slot       = out_slot_reg;
    assign wrap_total = out_wrap_reg;
    assign last       = out_last_reg;

    assign any_free = ~&active_reg;

    always_comb
    begin
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign rd_addr    = issue_reg[IDX_W-1:0];
    assign rd_period  = rd_data_reg[MEM_W-1:TIME_W];
    assign rd_ref     = rd_data_reg[TIME_W-1:0];
    assign elapsed    = now_reg - rd_ref;
    assign went_back  = now_reg < rd_ref;
    assign fires      = went_back ? (rd_period == '0) : (elapsed >= {1'b0, rd_period});
    assign chk_active = chk_valid_reg && active_reg[chk_idx_reg];
    assign q_we       = chk_active && fires && (fire_cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign q_waddr    = fire_cnt_reg[RES_IDX_W-1:0];
    assign res_total  = (fire_cnt_reg == '0) ? RES_CNT_W'(1) : fire_cnt_reg;
    assign emit_last  = (emit_reg + RES_CNT_W'(1)) == res_total;

    always_comb
    begin
        state_next       = state_reg;
        active_next      = active_reg;
        wrap_next        = wrap_reg;
        wrapped_next     = wrapped_reg;
        issue_next       = issue_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        fire_cnt_next    = fire_cnt_reg;
        emit_next        = emit_reg;
        now_next         = now_reg;
        single_kind_next = single_kind_reg;
        single_slot_next = single_slot_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_kind_next    = out_kind_reg;
        out_slot_next    = out_slot_reg;
        out_wrap_next    = out_wrap_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_waddr        = chk_idx_reg;
        mem_wdata        = {rd_period, now_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    fire_cnt_next = '0;
                    emit_next     = '0;
                    now_next      = now_ms;
                    if (command == CMD_ADD)
                    begin
                        state_next = ST_EMIT;
                        if (any_free)
                        begin
                            mem_we                = 1'b1;
                            mem_waddr             = free_idx;
                            mem_wdata             = {interval_ms, now_ms};
                            active_next[free_idx] = 1'b1;
                            single_kind_next      = KIND_ADDED;
                            single_slot_next      = SLOT_W'(free_idx);
                        end
                        else
                        begin
                            single_kind_next = KIND_REFUSED;
                            single_slot_next = '0;
                        end
                    end
                    else
                    begin
                        state_next       = ST_SCAN;
                        issue_next       = '0;
                        wrapped_next     = 1'b0;
                        single_kind_next = KIND_IDLE_TICK;
                        single_slot_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < CNT_W'(SLOT_COUNT))
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                if (chk_active)
                begin
                    if (went_back && !wrapped_reg)
                    begin
                        wrapped_next = 1'b1;
                        if (wrap_reg != WRAP_MAX)
                        begin
                            wrap_next = wrap_reg + WRAP_W'(1);
                        end
                    end
                    mem_we = went_back || fires;
                end
                if (q_we)
                begin
                    fire_cnt_next = fire_cnt_reg + RES_CNT_W'(1);
                end
                if (!chk_valid_reg && (issue_reg == CNT_W'(SLOT_COUNT)))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_wrap_next  = wrap_reg;
                    out_last_next  = emit_last;
                    if (fire_cnt_reg == '0)
                    begin
                        out_kind_next = single_kind_reg;
                        out_slot_next = single_slot_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_FIRED;
                        out_slot_next = queue_reg[emit_reg[RES_IDX_W-1:0]];
                    end
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg + RES_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            wrap_reg      <= '0;
            wrapped_reg   <= 1'b0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            fire_cnt_reg  <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            wrap_reg      <= wrap_next;
            wrapped_reg   <= wrapped_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            fire_cnt_reg  <= fire_cnt_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= chk_idx_next;
        now_reg         <= now_next;
        single_kind_reg <= single_kind_next;
        single_slot_reg <= single_slot_next;
        out_kind_reg    <= out_kind_next;
        out_slot_reg    <= out_slot_next;
        out_wrap_reg    <= out_wrap_next;
        out_last_reg    <= out_last_next;
        if (q_we)
        begin
            queue_reg[q_waddr] <= SLOT_W'(chk_idx_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // The fire queue never holds more entries than there are result places.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= RES_CNT_W'(MAX_RESULTS))
    else $error("fire count exceeds result capacity");

    // A slot check is only in flight while the scan runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> (state_reg == ST_SCAN))
    else $error("slot check outside scan");

    // The wrap counter only ever moves upwards.
    assert property (@(posedge clk) disable iff (!rst_n)
        wrap_reg >= $past(wrap_reg))
    else $error("wrap counter decreased");

    // The final result of a request returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && emit_last) |=> (state_reg == ST_IDLE))
    else $error("sequencer did not return to idle after last result");

    // Active flags are only ever set, and only by an add request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg != $past(active_reg)) |-> $past(in_accept && command == CMD_ADD))
    else $error("active flags changed without an add request");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the interval timer slot table.
`timescale 1ns / 100ps

module tb_top;
    import its_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int RANDOM_REQUESTS = 155;
    localparam int TAIL_TICKS = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [WRAP_W-1:0]   wraps;
        logic                last;
    } timer_result_t;

    typedef struct {
        logic                cmd;
        logic [TIME_W-1:0]   t;
        logic [PERIOD_W-1:0] iv;
        bit                  typed;
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [WRAP_W-1:0]   wraps;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                command = CMD_TICK;
    logic [TIME_W-1:0]   now_ms = '0;
    logic [PERIOD_W-1:0] interval_ms = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [WRAP_W-1:0]   wrap_total;
    logic                last;

    bit                  slot_live [SLOTS];
    logic [TIME_W-1:0]   slot_ref [SLOTS];
    logic [PERIOD_W-1:0] slot_period [SLOTS];
    int                  used_count;
    logic [WRAP_W-1:0]   wrap_count;

    timer_result_t       pending_results [$];
    timer_result_t       head;
    plan_row_t           plan [21];
    bit                  quiet = 1'b0;
    int                  stall_left = 0;
    int                  cycle_count = 0;
    int                  mismatches = 0;
    int                  results_checked = 0;
    int                  requests_sent = 0;
    logic [TIME_W-1:0]   clock_ms;
    int                  pick;
    int                  spare;

    interval_timer_slots dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .now_ms      (now_ms),
        .interval_ms (interval_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .slot        (slot),
        .wrap_total  (wrap_total),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void timer_table_step(input logic cmd, input logic [TIME_W-1:0] t,
            input logic [PERIOD_W-1:0] iv, input bit record);
        timer_result_t      burst [$];
        int                 free_idx;
        bit                 wrapped;
        logic [TIME_W-1:0]  elapsed;
        free_idx = -1;
        wrapped = 1'b0;
        if (cmd == CMD_ADD)
        begin
            if (used_count < SLOTS)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_live[i])
                    begin
                        free_idx = i;
                        break;
                    end
                end
            end
            if (free_idx < 0)
            begin
                burst.push_back('{KIND_REFUSED, SLOT_W'(0), WRAP_W'(0), 1'b0});
            end
            else
            begin
                slot_live[free_idx] = 1'b1;
                slot_period[free_idx] = iv;
                slot_ref[free_idx] = t;
                used_count++;
                burst.push_back('{KIND_ADDED, SLOT_W'(free_idx), WRAP_W'(0), 1'b0});
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_live[i])
                    continue;
                if (t < slot_ref[i])
                begin
                    if (!wrapped)
                    begin
                        if (wrap_count != WRAP_MAX)
                            wrap_count++;
                        wrapped = 1'b1;
                    end
                    slot_ref[i] = t;
                end
                elapsed = t - slot_ref[i];
                if (elapsed >= {1'b0, slot_period[i]})
                begin
                    slot_ref[i] = t;
                    if (burst.size() < MAX_RESULTS)
                        burst.push_back('{KIND_FIRED, SLOT_W'(i), WRAP_W'(0), 1'b0});
                end
            end
            if (burst.size() == 0)
                burst.push_back('{KIND_IDLE_TICK, SLOT_W'(0), WRAP_W'(0), 1'b0});
        end
        foreach (burst[k])
            burst[k].wraps = wrap_count;
        burst[burst.size() - 1].last = 1'b1;
        if (record)
        begin
            foreach (burst[k])
                pending_results.push_back(burst[k]);
        end
    endfunction

    task automatic send_request(input logic cmd, input logic [TIME_W-1:0] t,
            input logic [PERIOD_W-1:0] iv, input bit typed, input timer_result_t typed_res);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        now_ms <= t;
        interval_ms <= iv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed)
            pending_results.push_back(typed_res);
        timer_table_step(cmd, t, iv, !typed);
        requests_sent++;
    endtask

    always @(posedge clk)
    begin
        if (quiet || !rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, got kind %0d slot %0d wrap %0d last %0b",
                         $time, kind, slot, wrap_total, last);
            end
            else
            begin
                head = pending_results.pop_front();
                results_checked++;
                if ({kind, slot, wrap_total, last} !== head)
                begin
                    mismatches++;
                    $display(
                        "%0t: expected kind/slot/wrap/last %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                        $time, head.kind, head.slot, head.wraps, head.last,
                        kind, slot, wrap_total, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding",
                     $time, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_ref[i] = '0;
            slot_period[i] = '0;
        end
        used_count = 0;
        wrap_count = '0;
        plan = '{
            '{CMD_TICK, 32'h0000_0000, 31'h0000_0000, 1'b1, KIND_IDLE_TICK, 3'd0, 16'd0},
            '{CMD_TICK, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, KIND_IDLE_TICK, 3'd0, 16'd0},
            '{CMD_ADD,  32'd100,       31'd0,         1'b1, KIND_ADDED,     3'd0, 16'd0},
            '{CMD_TICK, 32'd100,       31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_ADD,  32'd200,       31'h7FFF_FFFF, 1'b1, KIND_ADDED,     3'd1, 16'd0},
            '{CMD_ADD,  32'd200,       31'd10,        1'b1, KIND_ADDED,     3'd2, 16'd0},
            '{CMD_ADD,  32'hFFFF_FFF0, 31'd50,        1'b1, KIND_ADDED,     3'd3, 16'd0},
            '{CMD_TICK, 32'd205,       31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'd215,       31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_ADD,  32'd215,       31'd1,         1'b1, KIND_ADDED,     3'd4, 16'd1},
            '{CMD_ADD,  32'd300,       31'd3,         1'b1, KIND_ADDED,     3'd5, 16'd1},
            '{CMD_ADD,  32'd300,       31'd100,       1'b1, KIND_ADDED,     3'd6, 16'd1},
            '{CMD_ADD,  32'd300,       31'd1000,      1'b1, KIND_ADDED,     3'd7, 16'd1},
            '{CMD_ADD,  32'd301,       31'd5,         1'b1, KIND_REFUSED,   3'd0, 16'd1},
            '{CMD_ADD,  32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, KIND_REFUSED,   3'd0, 16'd1},
            '{CMD_TICK, 32'd400,       31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'd50,        31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'd50,        31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'h8000_0100, 31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'h8000_0100, 31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0},
            '{CMD_TICK, 32'h0000_0000, 31'd0,         1'b0, KIND_FIRED,     3'd0, 16'd0}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_request(plan[i].cmd, plan[i].t, plan[i].iv, plan[i].typed,
                         '{plan[i].kind, plan[i].slot, plan[i].wraps, 1'b1});

        clock_ms = 32'd1000;
        repeat (RANDOM_REQUESTS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_request(CMD_ADD, $urandom(), PERIOD_W'($urandom()), 1'b0, '0);
            end
            else
            begin
                if (pick < 20)
                    clock_ms = clock_ms - $urandom_range(1, 5000);
                else if (pick < 25)
                    clock_ms = $urandom();
                else if (pick < 30)
                    clock_ms = clock_ms + 32'h8000_0000 + $urandom_range(0, 300);
                else
                    clock_ms = clock_ms + $urandom_range(0, 120);
                send_request(CMD_TICK, clock_ms, PERIOD_W'($urandom()), 1'b0, '0);
            end
        end

        // Hold the request side off until every outstanding result has been seen.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        // Time runs backwards on every tick after the first from here, with no idling on either side.
        quiet = 1'b1;
        clock_ms = 32'hFFFF_FFFF;
        spare = 0;
        while (spare < TAIL_TICKS)
        begin
            if (spare % 8 == 3)
                send_request(CMD_ADD, $urandom(), PERIOD_W'($urandom()), 1'b0, '0);
            send_request(CMD_TICK, clock_ms, PERIOD_W'($urandom()), 1'b0, '0);
            clock_ms = clock_ms - 1;
            spare++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Sent %0d requests and checked %0d results; %0d of %0d slots claimed.",
                 requests_sent, results_checked, used_count, SLOTS);
        $display("Wrap total ended at %0d after a closing run of backwards ticks with no idling.",
                 wrap_count);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
